// File: hw/rtl/windowed_noise_snr_estimator_core_assert.svh
// Assertion macros for the windowed noise SNR estimator.
`ifndef WINDOWED_NOISE_SNR_ESTIMATOR_CORE_ASSERT_SVH
`define WINDOWED_NOISE_SNR_ESTIMATOR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define WNSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`define WNSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");

`else

`define WNSE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WNSE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/wnse_pkg.sv
// Types and constants of the windowed noise SNR estimator.
`timescale 1ns / 1ps

package wnse_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int POWER_W   = 32;
    localparam int SKIP_W    = 12;
    localparam int WIN_W     = 13;
    localparam int PHASE_W   = 14;
    localparam int ACC_W     = 44;
    localparam int MAG_W     = 32;
    localparam int SNR_W     = 32;
    localparam int TOTAL_W   = 48;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 4;

    localparam int DIV_DIVIDEND_W = 48;
    localparam int DIV_DIVISOR_W  = 32;
    localparam int DIV_CNT_W      = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_DIVIDEND_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LENGTH   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 4'd1;

    localparam logic [SKIP_W-1:0] SKIP_RESET = 12'd0;
    localparam logic [WIN_W-1:0]  WIN_RESET  = 13'd64;

    localparam logic signed [SNR_W-1:0]   SNR_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [SNR_W-1:0]   SNR_MIN   = 32'sh8000_0000;
    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = 48'sh8000_0000_0000;
    localparam logic [COUNT_W-1:0]        COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_I,
        ST_MUL_Q,
        ST_UPDATE,
        ST_DIV_NOISE,
        ST_SNR_PREP,
        ST_DIV_SNR,
        ST_SNR_SAT,
        ST_TOTAL,
        ST_EMIT
    } state_t;

endpackage

// File: hw/rtl/windowed_noise_snr_estimator_core.sv
// Windowed noise SNR estimator: sequenced core with shared multiplier and divider.
`timescale 1ns / 1ps

// Each accepted sample comes back once on the output channel, unchanged, with
// estimate fields. An ordinary sample goes from acceptance to the next
// acceptance through two passes of one shared 16x16 multiplier, an
// accumulate step, and the output load. The sample that closes a noise
// window also runs the shared radix-2 divider: 48 steps for the window
// average and 48 more for the Q16.16 SNR quotient; when the window
// average is zero the second pass is skipped. A finished result sits in the
// output register while the next sample is accepted; a result not yet taken
// holds the core in its output step. Configuration writes are taken only
// while the core is idle; writes to the skip or window length abort any
// estimate in progress.
module windowed_noise_snr_estimator_core
    import wnse_pkg::*;
#(
    parameter int MAX_WINDOW = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [SAMPLE_W-1:0]  sample_i,
    input  logic signed [SAMPLE_W-1:0]  sample_q,
    input  logic                        tag_present,
    input  logic [POWER_W-1:0]          signal_power,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  out_i,
    output logic signed [SAMPLE_W-1:0]  out_q,
    output logic                        estimate_valid,
    output logic signed [SNR_W-1:0]     snr_linear,
    output logic [POWER_W-1:0]          noise_power,
    output logic signed [TOTAL_W-1:0]   snr_total,
    output logic [COUNT_W-1:0]          estimate_count,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [31:0]                 cfg_data
);

`include "windowed_noise_snr_estimator_core_assert.svh"

    localparam logic [16:0] MaxWin = 17'(MAX_WINDOW);

    state_t state_reg, state_next;

    logic                       busy_reg, busy_next;
    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [POWER_W-1:0]         held_reg, held_next;
    logic signed [TOTAL_W-1:0]  sum_reg, sum_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic [SKIP_W-1:0]          skip_reg, skip_next;
    logic [WIN_W-1:0]           win_reg, win_next;
    logic [DIV_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                       est_reg, est_next;
    logic                       out_valid_reg, out_valid_next;

    logic signed [SAMPLE_W-1:0] samp_i_reg, samp_i_next;
    logic signed [SAMPLE_W-1:0] samp_q_reg, samp_q_next;
    logic                       tag_reg, tag_next;
    logic [POWER_W-1:0]         power_reg, power_next;
    logic [MAG_W-1:0]           mag_reg, mag_next;
    logic [DIV_DIVISOR_W:0]     rem_reg, rem_next;
    logic [DIV_DIVIDEND_W-1:0]  quo_reg, quo_next;
    logic [DIV_DIVISOR_W-1:0]   div_reg, div_next;
    logic [POWER_W-1:0]         noise_reg, noise_next;
    logic                       neg_reg, neg_next;
    logic signed [SNR_W-1:0]    snr_reg, snr_next;

    logic signed [SAMPLE_W-1:0] oi_reg, oi_next;
    logic signed [SAMPLE_W-1:0] oq_reg, oq_next;
    logic                       oest_reg, oest_next;
    logic signed [SNR_W-1:0]    osnr_reg, osnr_next;
    logic [POWER_W-1:0]         onoise_reg, onoise_next;
    logic signed [TOTAL_W-1:0]  ototal_reg, ototal_next;
    logic [COUNT_W-1:0]         ocount_reg, ocount_next;

    logic                       mul_sel_q;
    logic                       div_run;
    logic                       in_fire;
    logic                       cfg_fire;
    logic                       out_free;
    logic [WIN_W-1:0]           weff;
    logic [PHASE_W-1:0]         limit;
    logic                       closes;
    logic signed [SAMPLE_W-1:0] mul_op;
    logic signed [2*SAMPLE_W-1:0] prod;
    logic [DIV_DIVISOR_W:0]     rem_sh;
    logic [DIV_DIVISOR_W+1:0]   trial;
    logic signed [POWER_W+1:0]  diff;
    logic [POWER_W+1:0]         diff_abs;
    logic signed [TOTAL_W:0]    sum_wide;

    // Effective window and window-closing limit
    always_comb
    begin
        if (win_reg == '0)
        begin
            weff = WIN_W'(1);
        end
        else if ({4'b0, win_reg} > MaxWin)
        begin
            weff = MaxWin[WIN_W-1:0];
        end
        else
        begin
            weff = win_reg;
        end
        limit  = {2'b0, skip_reg} + {1'b0, weff};
        closes = busy_reg && ((phase_reg + PHASE_W'(1)) == limit);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_fire) state_next = ST_MUL_I;
            ST_MUL_I:     state_next = ST_MUL_Q;
            ST_MUL_Q:     state_next = ST_UPDATE;
            ST_UPDATE:    state_next = closes ? ST_DIV_NOISE : ST_EMIT;
            ST_DIV_NOISE: if (cnt_reg == DIV_LAST) state_next = ST_SNR_PREP;
            ST_SNR_PREP:  state_next = (quo_reg[POWER_W-1:0] == '0) ? ST_TOTAL : ST_DIV_SNR;
            ST_DIV_SNR:   if (cnt_reg == DIV_LAST) state_next = ST_SNR_SAT;
            ST_SNR_SAT:   state_next = ST_TOTAL;
            ST_TOTAL:     state_next = ST_EMIT;
            ST_EMIT:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        cfg_ready = 1'b0;
        in_ready  = 1'b0;
        mul_sel_q = 1'b0;
        div_run   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cfg_ready = 1'b1;
                in_ready  = !cfg_valid;
            end
            ST_MUL_Q:
            begin
                mul_sel_q = 1'b1;
            end
            ST_DIV_NOISE, ST_DIV_SNR:
            begin
                div_run = 1'b1;
            end
            default:
            begin
                cfg_ready = 1'b0;
            end
        endcase
    end

    assign in_fire  = in_valid && in_ready;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Shared multiplier and divider step, SNR difference and running total sum
    always_comb
    begin
        mul_op   = mul_sel_q ? samp_q_reg : samp_i_reg;
        prod     = mul_op * mul_op;
        rem_sh   = {rem_reg[DIV_DIVISOR_W-1:0], quo_reg[DIV_DIVIDEND_W-1]};
        trial    = {1'b0, rem_sh} - {2'b0, div_reg};
        diff     = $signed({2'b0, held_reg}) - $signed({2'b0, quo_reg[POWER_W-1:0]});
        diff_abs = diff[POWER_W+1] ? (~diff + 1'b1) : diff;
        sum_wide = $signed({sum_reg[TOTAL_W-1], sum_reg})
                 + $signed({{(TOTAL_W-SNR_W+1){snr_reg[SNR_W-1]}}, snr_reg});
    end

    // Datapath next values
    always_comb
    begin
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        held_next      = held_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        skip_next      = skip_reg;
        win_next       = win_reg;
        cnt_next       = cnt_reg;
        est_next       = est_reg;
        out_valid_next = out_valid_reg;
        samp_i_next    = samp_i_reg;
        samp_q_next    = samp_q_reg;
        tag_next       = tag_reg;
        power_next     = power_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        noise_next     = noise_reg;
        neg_next       = neg_reg;
        snr_next       = snr_reg;
        oi_next        = oi_reg;
        oq_next        = oq_reg;
        oest_next      = oest_reg;
        osnr_next      = osnr_reg;
        onoise_next    = onoise_reg;
        ototal_next    = ototal_reg;
        ocount_next    = ocount_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_fire)
        begin
            busy_next = 1'b0;
            if (cfg_index == CFG_SKIP_LENGTH)
            begin
                skip_next = cfg_data[SKIP_W-1:0];
            end
            else if (cfg_index == CFG_WINDOW_LENGTH)
            begin
                win_next = cfg_data[WIN_W-1:0];
            end
            else
            begin
                busy_next = busy_reg;
            end
        end

        if (in_fire)
        begin
            samp_i_next = sample_i;
            samp_q_next = sample_q;
            tag_next    = tag_present;
            power_next  = signal_power;
            est_next    = 1'b0;
        end

        if (state_reg == ST_MUL_I)
        begin
            mag_next = MAG_W'($unsigned(prod));
        end

        if (state_reg == ST_MUL_Q)
        begin
            mag_next = mag_reg + MAG_W'($unsigned(prod));
        end

        if (state_reg == ST_UPDATE)
        begin
            if (busy_reg)
            begin
                if (phase_reg >= {2'b0, skip_reg})
                begin
                    acc_next = acc_reg + {{(ACC_W-MAG_W){1'b0}}, mag_reg};
                end
                phase_next = phase_reg + PHASE_W'(1);
                if (closes)
                begin
                    busy_next = 1'b0;
                    est_next  = 1'b1;
                    rem_next  = '0;
                    quo_next  = DIV_DIVIDEND_W'(acc_next);
                    div_next  = DIV_DIVISOR_W'(weff);
                    cnt_next  = '0;
                end
            end
            else if (tag_reg)
            begin
                busy_next  = 1'b1;
                phase_next = '0;
                acc_next   = '0;
                held_next  = power_reg;
            end
        end

        if (div_run)
        begin
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (!trial[DIV_DIVISOR_W+1])
            begin
                rem_next = trial[DIV_DIVISOR_W:0];
                quo_next = {quo_reg[DIV_DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DIV_DIVIDEND_W-2:0], 1'b0};
            end
        end

        if (state_reg == ST_SNR_PREP)
        begin
            noise_next = quo_reg[POWER_W-1:0];
            neg_next   = diff[POWER_W+1];
            rem_next   = '0;
            quo_next   = {diff_abs[POWER_W-1:0], 16'b0};
            div_next   = quo_reg[POWER_W-1:0];
            cnt_next   = '0;
            snr_next   = SNR_MAX;
        end

        if (state_reg == ST_SNR_SAT)
        begin
            if (neg_reg)
            begin
                if (quo_reg > DIV_DIVIDEND_W'(33'h1_0000_0000 >> 1))
                begin
                    snr_next = SNR_MIN;
                end
                else
                begin
                    snr_next = $signed(SNR_W'(0) - quo_reg[SNR_W-1:0]);
                end
            end
            else if (quo_reg > DIV_DIVIDEND_W'(SNR_MAX))
            begin
                snr_next = SNR_MAX;
            end
            else
            begin
                snr_next = $signed(quo_reg[SNR_W-1:0]);
            end
        end

        if (state_reg == ST_TOTAL)
        begin
            if (sum_wide[TOTAL_W] != sum_wide[TOTAL_W-1])
            begin
                sum_next = sum_wide[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
            end
            else
            begin
                sum_next = sum_wide[TOTAL_W-1:0];
            end
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end

        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_valid_next = 1'b1;
            oi_next        = samp_i_reg;
            oq_next        = samp_q_reg;
            oest_next      = est_reg;
            osnr_next      = est_reg ? snr_reg : '0;
            onoise_next    = est_reg ? noise_reg : '0;
            ototal_next    = est_reg ? sum_reg : '0;
            ocount_next    = est_reg ? count_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= 1'b0;
            phase_reg     <= '0;
            acc_reg       <= '0;
            held_reg      <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            skip_reg      <= SKIP_RESET;
            win_reg       <= WIN_RESET;
            cnt_reg       <= '0;
            est_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            skip_reg      <= skip_next;
            win_reg       <= win_next;
            cnt_reg       <= cnt_next;
            est_reg       <= est_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_i_reg <= samp_i_next;
        samp_q_reg <= samp_q_next;
        tag_reg    <= tag_next;
        power_reg  <= power_next;
        mag_reg    <= mag_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        div_reg    <= div_next;
        noise_reg  <= noise_next;
        neg_reg    <= neg_next;
        snr_reg    <= snr_next;
        oi_reg     <= oi_next;
        oq_reg     <= oq_next;
        oest_reg   <= oest_next;
        osnr_reg   <= osnr_next;
        onoise_reg <= onoise_next;
        ototal_reg <= ototal_next;
        ocount_reg <= ocount_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_i          = oi_reg;
    assign out_q          = oq_reg;
    assign estimate_valid = oest_reg;
    assign snr_linear     = osnr_reg;
    assign noise_power    = onoise_reg;
    assign snr_total      = ototal_reg;
    assign estimate_count = ocount_reg;

    `WNSE_ASSERT_IMP(a_busy_blocks_ports, clk, rst_n, state_reg != ST_IDLE, !in_ready && !cfg_ready)
    `WNSE_ASSERT_NXT(a_accept_starts_mul, clk, rst_n, in_valid && in_ready, state_reg == ST_MUL_I)
    `WNSE_ASSERT_IMP(a_idle_fields_zero, clk, rst_n, out_valid && !estimate_valid, snr_linear == '0 && noise_power == '0 && snr_total == '0 && estimate_count == '0)
    `WNSE_ASSERT_IMP(a_count_nonzero, clk, rst_n, out_valid && estimate_valid, estimate_count != '0)

endmodule
